// ===== sv/btd_pkg.sv =====
// Types, codes and fixed constants shared by the bumper threshold detector.
package btd_pkg;

    // Fixed field widths of the request and result items.
    localparam int SAMPLE_BITS = 12;
    localparam int CHANNELS    = 7;
    localparam int CH_W        = 3;
    localparam int KIND_W      = 2;
    localparam int DIR_W       = 3;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 12;
    localparam int SKIP_W      = 8;
    localparam int LEVEL_W     = 12;
    localparam int MARGIN_W    = 8;

    // Request kinds.
    typedef enum logic [KIND_W-1:0] {
        KIND_SAMPLE   = 2'd0,
        KIND_EVALUATE = 2'd1,
        KIND_CLEAR    = 2'd2
    } t_kind;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SKIP_COUNT    = 3'd0,
        CFG_FLOOR_LEVEL   = 3'd1,
        CFG_CORNER_CAP    = 3'd2,
        CFG_CORNER_KNEE   = 3'd3,
        CFG_RECALC_MARGIN = 3'd4
    } t_cfg_reg;

    // Register values after reset.
    localparam logic [SKIP_W-1:0]   SKIP_COUNT_RST    = 8'd180;
    localparam logic [LEVEL_W-1:0]  FLOOR_LEVEL_RST   = 12'd400;
    localparam logic [LEVEL_W-1:0]  CORNER_CAP_RST    = 12'd300;
    localparam logic [LEVEL_W-1:0]  CORNER_KNEE_RST   = 12'd330;
    localparam logic [MARGIN_W-1:0] RECALC_MARGIN_RST = 8'd5;

    // Channel numbering.
    localparam logic [CH_W-1:0] CH_LEFT_SIDE    = 3'd0;
    localparam logic [CH_W-1:0] CH_RIGHT_SIDE   = 3'd1;
    localparam logic [CH_W-1:0] CH_LEFT_CORNER  = 3'd2;
    localparam logic [CH_W-1:0] CH_FRONT_LEFT   = 3'd3;
    localparam logic [CH_W-1:0] CH_FRONT_RIGHT  = 3'd4;
    localparam logic [CH_W-1:0] CH_RIGHT_CORNER = 3'd5;
    localparam logic [CH_W-1:0] CH_BACK         = 3'd6;

    // Move directions that force a corner threshold refresh.
    localparam logic [DIR_W-1:0] DIR_LEFT_CORNER_MASK  = 3'b101;
    localparam logic [DIR_W-1:0] DIR_RIGHT_CORNER_MASK = 3'b110;

    // Exact floor division by five of a value below 2^DIV5_IN_W by a reciprocal.
    localparam int DIV5_IN_W  = SAMPLE_BITS + 3;
    localparam int DIV5_OUT_W = DIV5_IN_W - 2;
    localparam int DIV5_SH    = DIV5_IN_W + 3;
    localparam int DIV5_M_W   = DIV5_IN_W + 1;
    localparam int DIV5_P_W   = DIV5_IN_W + DIV5_M_W;
    localparam logic [DIV5_M_W-1:0] DIV5_MAGIC = DIV5_M_W'(((1 << DIV5_SH) + 4) / 5);

    // Request item.
    typedef struct packed {
        logic [KIND_W-1:0]      kind;
        logic [SAMPLE_BITS-1:0] sample;
        logic [DIR_W-1:0]       move_dir;
    } t_in_item;

    // Result item.
    typedef struct packed {
        logic left_pressed;
        logic right_pressed;
        logic reverse_pressed;
        logic armed;
    } t_out_item;

    // Pressed flags kept between evaluations.
    typedef struct packed {
        logic left;
        logic right;
        logic reverse;
    } t_press_flags;

    // Floor of x / 5.
    function automatic logic [DIV5_OUT_W-1:0] div5(input logic [DIV5_IN_W-1:0] x);
        logic [DIV5_P_W-1:0] prod;
        prod = DIV5_P_W'(x) * DIV5_P_W'(DIV5_MAGIC);
        return prod[DIV5_SH +: DIV5_OUT_W];
    endfunction

endpackage

// ===== sv/bumper_threshold_detector.sv =====
// Bumper threshold detector: sample rings in memory, averaging pipeline and evaluation.
//
// Converter samples are decimated and the kept ones are spread round robin over seven
// channel rings held in one synchronous memory of 7 x RING_DEPTH entries. A kept sample
// reads the slot it replaces, writes it back with the channel's updated running sum in
// the next cycle, and the channel's average and candidate thresholds follow through the
// r_s2_sum and r_s3_avg registers. Sample and clear requests are taken every cycle. An
// evaluate request waits while a kept sample's update is still in flight in the s1, s2
// or s3 stage, and waits while the result register is full and stalled. Each evaluate
// gives one result; other requests give none. Thresholds arm on the first evaluate after
// every ring holds RING_DEPTH-1 samples. No clearing pass is needed after reset: a
// per-channel wrap flag marks ring slots that have never been written.
module bumper_threshold_detector #(
    parameter int RING_DEPTH = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  btd_pkg::t_in_item               i_in,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output btd_pkg::t_out_item              o_out,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [btd_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [btd_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import btd_pkg::*;

    localparam int POS_W     = $clog2(RING_DEPTH);
    localparam int SUM_W     = SAMPLE_BITS + POS_W;
    localparam int ENTRIES   = CHANNELS * RING_DEPTH;
    localparam int ADDR_W    = $clog2(ENTRIES);
    localparam int AVG_SH    = SUM_W + POS_W;
    localparam int AVG_M_W   = SUM_W + 1;
    localparam int AVG_P_W   = SUM_W + AVG_M_W;
    localparam longint unsigned AVG_MAGIC_L =
        ((64'd1 << AVG_SH) + RING_DEPTH - 1) / RING_DEPTH;
    localparam logic [AVG_M_W-1:0] AVG_MAGIC = AVG_M_W'(AVG_MAGIC_L);
    localparam logic [POS_W-1:0]   POS_LAST  = POS_W'(RING_DEPTH - 1);

    // Configuration registers.
    logic [SKIP_W-1:0]   r_skip_count;
    logic [LEVEL_W-1:0]  r_floor_level;
    logic [LEVEL_W-1:0]  r_corner_cap;
    logic [LEVEL_W-1:0]  r_corner_knee;
    logic [MARGIN_W-1:0] r_recalc_margin;

    // Ring bookkeeping and channel state.
    logic [SAMPLE_BITS-1:0] r_ring_mem [ENTRIES];
    logic [SAMPLE_BITS-1:0] r_rd_data;
    logic [POS_W-1:0]       r_pos      [CHANNELS];
    logic [POS_W-1:0]       r_fill     [CHANNELS];
    logic [CHANNELS-1:0]    r_wrapped;
    logic [SUM_W-1:0]       r_sum      [CHANNELS];
    logic [SAMPLE_BITS-1:0] r_avg      [CHANNELS];
    logic [SAMPLE_BITS-1:0] r_side     [CHANNELS];
    logic [SAMPLE_BITS-1:0] r_half     [CHANNELS];
    logic [SAMPLE_BITS-1:0] r_four5    [CHANNELS];
    logic [LEVEL_W-1:0]     r_thr      [CHANNELS];
    logic [SAMPLE_BITS-1:0] r_left_ref;
    logic [SAMPLE_BITS-1:0] r_right_ref;
    logic [CH_W-1:0]        r_active_ch;
    logic [SKIP_W-1:0]      r_skip_cnt;
    t_press_flags           r_flags;

    // Update pipeline: slot read, sum write-back, average, candidate thresholds.
    logic                   r_s1_valid;
    logic [CH_W-1:0]        r_s1_ch;
    logic [ADDR_W-1:0]      r_s1_addr;
    logic [SAMPLE_BITS-1:0] r_s1_sample;
    logic                   r_s1_wrapped;
    logic                   r_s2_valid;
    logic [CH_W-1:0]        r_s2_ch;
    logic [SUM_W-1:0]       r_s2_sum;
    logic                   r_s3_valid;
    logic [CH_W-1:0]        r_s3_ch;
    logic [SAMPLE_BITS-1:0] r_s3_avg;

    // Result register.
    logic      r_out_valid;
    t_out_item r_out;

    logic                   in_accept;
    logic                   is_sample;
    logic                   is_eval;
    logic                   is_clear;
    logic                   keep;
    logic                   pipe_busy;
    logic [ADDR_W-1:0]      rd_addr;
    logic [SAMPLE_BITS-1:0] old_sample;
    logic [SUM_W-1:0]       n_sum;
    logic [AVG_P_W-1:0]     avg_prod;
    logic [SAMPLE_BITS-1:0] n_avg;
    logic [DIV5_IN_W-1:0]   side_num;
    logic [DIV5_IN_W-1:0]   four_num;
    logic [SAMPLE_BITS-1:0] n_side;
    logic [SAMPLE_BITS-1:0] n_four5;

    logic                   all_full;
    logic                   arm;
    logic                   armed_now;
    logic [LEVEL_W-1:0]     thr_base  [CHANNELS];
    logic [LEVEL_W-1:0]     n_thr     [CHANNELS];
    logic [SAMPLE_BITS-1:0] left_base;
    logic [SAMPLE_BITS-1:0] right_base;
    logic [SAMPLE_BITS-1:0] n_left_ref;
    logic [SAMPLE_BITS-1:0] n_right_ref;
    t_press_flags           n_flags;

    // Raise a threshold to the floor level.
    function automatic logic [LEVEL_W-1:0] floored(
        input logic [SAMPLE_BITS-1:0] t,
        input logic [LEVEL_W-1:0]     lvl
    );
        return (LEVEL_W'(t) < lvl) ? lvl : LEVEL_W'(t);
    endfunction

    // Corner threshold from the average and its four-fifths value.
    function automatic logic [LEVEL_W-1:0] corner_th(
        input logic [SAMPLE_BITS-1:0] avg,
        input logic [SAMPLE_BITS-1:0] four5,
        input logic [LEVEL_W-1:0]     knee,
        input logic [LEVEL_W-1:0]     cap
    );
        logic [LEVEL_W-1:0] t;
        if (LEVEL_W'(avg) > knee) begin
            t = cap;
        end else if (LEVEL_W'(four5) > cap) begin
            t = cap;
        end else begin
            t = LEVEL_W'(four5);
        end
        return t;
    endfunction

    // Request decode and handshake.
    assign is_sample   = (i_in.kind == KIND_SAMPLE);
    assign is_eval     = (i_in.kind == KIND_EVALUATE);
    assign is_clear    = (i_in.kind == KIND_CLEAR);
    assign pipe_busy   = r_s1_valid | r_s2_valid | r_s3_valid;
    assign o_in_stall  = is_eval & (pipe_busy | (r_out_valid & i_out_stall));
    assign in_accept   = i_in_valid & ~o_in_stall;
    assign keep        = (r_skip_cnt >= r_skip_count);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // Address of the slot that the next kept sample replaces.
    assign rd_addr = ADDR_W'(int'(r_active_ch) * RING_DEPTH + int'(r_pos[r_active_ch]));

    // Running sum of the channel in the write-back stage.
    assign old_sample = r_s1_wrapped ? r_rd_data : '0;
    assign n_sum = r_sum[r_s1_ch] - SUM_W'(old_sample) + SUM_W'(r_s1_sample);

    // Average by exact reciprocal multiplication.
    assign avg_prod = AVG_P_W'(r_s2_sum) * AVG_P_W'(AVG_MAGIC);
    assign n_avg    = avg_prod[AVG_SH +: SAMPLE_BITS];

    // Candidate thresholds: floor(17*avg/20) and floor(4*avg/5).
    assign side_num = DIV5_IN_W'((SAMPLE_BITS + 5)'(r_s3_avg) * (SAMPLE_BITS + 5)'(17) >> 2);
    assign four_num = DIV5_IN_W'({r_s3_avg, 2'b00});
    assign n_side   = SAMPLE_BITS'(div5(side_num));
    assign n_four5  = SAMPLE_BITS'(div5(four_num));

    // Evaluation: arming, flag computation and corner refresh.
    always_comb begin
        all_full = 1'b1;
        for (int c = 0; c < CHANNELS; c++) begin
            if (r_fill[c] != POS_LAST) all_full = 1'b0;
        end
        arm = (r_thr[CH_LEFT_SIDE] == '0) && all_full;

        for (int c = 0; c < CHANNELS; c++) begin
            thr_base[c] = r_thr[c];
        end
        left_base  = r_left_ref;
        right_base = r_right_ref;
        if (arm) begin
            thr_base[CH_LEFT_SIDE]    = floored(r_side[CH_LEFT_SIDE], r_floor_level);
            thr_base[CH_RIGHT_SIDE]   = floored(r_side[CH_RIGHT_SIDE], r_floor_level);
            thr_base[CH_LEFT_CORNER]  = corner_th(r_avg[CH_LEFT_CORNER],
                                                  r_four5[CH_LEFT_CORNER],
                                                  r_corner_knee, r_corner_cap);
            thr_base[CH_FRONT_LEFT]   = floored(r_half[CH_FRONT_LEFT], r_floor_level);
            thr_base[CH_FRONT_RIGHT]  = floored(r_half[CH_FRONT_RIGHT], r_floor_level);
            thr_base[CH_RIGHT_CORNER] = corner_th(r_avg[CH_RIGHT_CORNER],
                                                  r_four5[CH_RIGHT_CORNER],
                                                  r_corner_knee, r_corner_cap);
            thr_base[CH_BACK]         = floored(r_side[CH_BACK], r_floor_level);
            left_base  = r_avg[CH_LEFT_CORNER];
            right_base = r_avg[CH_RIGHT_CORNER];
        end
        armed_now = (thr_base[CH_LEFT_SIDE] != '0);

        for (int c = 0; c < CHANNELS; c++) begin
            n_thr[c] = thr_base[c];
        end
        n_left_ref  = left_base;
        n_right_ref = right_base;
        n_flags     = r_flags;
        if (armed_now) begin
            n_flags.left  = (LEVEL_W'(r_avg[CH_LEFT_SIDE]) < thr_base[CH_LEFT_SIDE]);
            n_flags.right = (LEVEL_W'(r_avg[CH_RIGHT_SIDE]) < thr_base[CH_RIGHT_SIDE]);
            n_flags.reverse = 1'b0;
            if (LEVEL_W'(r_avg[CH_BACK]) < thr_base[CH_BACK]) begin
                n_flags = '{left: 1'b1, right: 1'b1, reverse: 1'b1};
            end
            // A refresh on the move direction makes the rise test false afterwards.
            if (((i_in.move_dir & DIR_LEFT_CORNER_MASK) != '0) ||
                ((SAMPLE_BITS + 1)'(left_base) + (SAMPLE_BITS + 1)'(r_recalc_margin) <
                 (SAMPLE_BITS + 1)'(r_avg[CH_LEFT_CORNER]))) begin
                n_thr[CH_LEFT_CORNER] = corner_th(r_avg[CH_LEFT_CORNER],
                                                  r_four5[CH_LEFT_CORNER],
                                                  r_corner_knee, r_corner_cap);
                n_left_ref = r_avg[CH_LEFT_CORNER];
            end
            if (((i_in.move_dir & DIR_RIGHT_CORNER_MASK) != '0) ||
                ((SAMPLE_BITS + 1)'(right_base) + (SAMPLE_BITS + 1)'(r_recalc_margin) <
                 (SAMPLE_BITS + 1)'(r_avg[CH_RIGHT_CORNER]))) begin
                n_thr[CH_RIGHT_CORNER] = corner_th(r_avg[CH_RIGHT_CORNER],
                                                   r_four5[CH_RIGHT_CORNER],
                                                   r_corner_knee, r_corner_cap);
                n_right_ref = r_avg[CH_RIGHT_CORNER];
            end
        end
    end

    // Ring memory: slot read on a kept sample, write-back in the next cycle.
    always_ff @(posedge i_clk) begin
        if (r_s1_valid) begin
            r_ring_mem[r_s1_addr] <= r_s1_sample;
        end
        if (in_accept && is_sample && keep) begin
            r_rd_data <= r_ring_mem[rd_addr];
        end
    end

    // Pipeline payload.
    always_ff @(posedge i_clk) begin
        if (in_accept && is_sample && keep) begin
            r_s1_ch      <= r_active_ch;
            r_s1_addr    <= rd_addr;
            r_s1_sample  <= i_in.sample;
            r_s1_wrapped <= r_wrapped[r_active_ch];
        end
        if (r_s1_valid) begin
            r_s2_ch  <= r_s1_ch;
            r_s2_sum <= n_sum;
        end
        if (r_s2_valid) begin
            r_s3_ch  <= r_s2_ch;
            r_s3_avg <= n_avg;
        end
        if (in_accept && is_eval) begin
            r_out <= '{left_pressed:    n_flags.left,
                       right_pressed:   n_flags.right,
                       reverse_pressed: n_flags.reverse,
                       armed:           armed_now};
        end
    end

    // Control and channel state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skip_count    <= SKIP_COUNT_RST;
            r_floor_level   <= FLOOR_LEVEL_RST;
            r_corner_cap    <= CORNER_CAP_RST;
            r_corner_knee   <= CORNER_KNEE_RST;
            r_recalc_margin <= RECALC_MARGIN_RST;
            for (int c = 0; c < CHANNELS; c++) begin
                r_pos[c]   <= '0;
                r_fill[c]  <= '0;
                r_sum[c]   <= '0;
                r_avg[c]   <= '0;
                r_side[c]  <= '0;
                r_half[c]  <= '0;
                r_four5[c] <= '0;
                r_thr[c]   <= '0;
            end
            r_wrapped   <= '0;
            r_left_ref  <= '0;
            r_right_ref <= '0;
            r_active_ch <= '0;
            r_skip_cnt  <= '0;
            r_flags     <= '0;
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_s3_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            // Configuration writes.
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_SKIP_COUNT:    r_skip_count    <= i_cfg_data[SKIP_W-1:0];
                    CFG_FLOOR_LEVEL:   r_floor_level   <= i_cfg_data[LEVEL_W-1:0];
                    CFG_CORNER_CAP:    r_corner_cap    <= i_cfg_data[LEVEL_W-1:0];
                    CFG_CORNER_KNEE:   r_corner_knee   <= i_cfg_data[LEVEL_W-1:0];
                    CFG_RECALC_MARGIN: r_recalc_margin <= i_cfg_data[MARGIN_W-1:0];
                    default: ;
                endcase
            end

            // Decimator and ring pointers.
            r_s1_valid <= in_accept && is_sample && keep;
            if (in_accept && is_sample) begin
                if (keep) begin
                    r_skip_cnt <= '0;
                    if (r_pos[r_active_ch] == POS_LAST) begin
                        r_pos[r_active_ch]     <= '0;
                        r_wrapped[r_active_ch] <= 1'b1;
                    end else begin
                        r_pos[r_active_ch] <= r_pos[r_active_ch] + 1'b1;
                    end
                    if (r_fill[r_active_ch] != POS_LAST) begin
                        r_fill[r_active_ch] <= r_fill[r_active_ch] + 1'b1;
                    end
                    r_active_ch <= (r_active_ch == CH_BACK) ? '0 : r_active_ch + 1'b1;
                end else begin
                    r_skip_cnt <= r_skip_cnt + 1'b1;
                end
            end

            // Sum write-back, average and candidate thresholds.
            r_s2_valid <= r_s1_valid;
            if (r_s1_valid) begin
                r_sum[r_s1_ch] <= n_sum;
            end
            r_s3_valid <= r_s2_valid;
            if (r_s3_valid) begin
                r_avg[r_s3_ch]   <= r_s3_avg;
                r_side[r_s3_ch]  <= n_side;
                r_half[r_s3_ch]  <= r_s3_avg >> 1;
                r_four5[r_s3_ch] <= n_four5;
            end

            // Evaluate and clear requests.
            if (in_accept && is_eval) begin
                for (int c = 0; c < CHANNELS; c++) begin
                    r_thr[c] <= n_thr[c];
                end
                r_left_ref  <= n_left_ref;
                r_right_ref <= n_right_ref;
                r_flags     <= n_flags;
            end else if (in_accept && is_clear) begin
                for (int c = 0; c < CHANNELS; c++) begin
                    r_thr[c] <= '0;
                end
            end

            // Result register.
            if (in_accept && is_eval) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

// ===== bench/bumper_threshold_detector_tb.sv =====
// Self-checking testbench for the bumper threshold detector, with its own model of the block.
`timescale 1ns / 100ps

module bumper_threshold_detector_tb;
    import btd_pkg::*;

    localparam int  CLK_PERIOD     = 10;
    localparam int  RING_DEPTH     = 16;
    localparam int  SAMPLE_MAX     = (1 << SAMPLE_BITS) - 1;
    localparam int  SETTLE_CYCLES  = 8;
    localparam int  HOLD_CYCLES    = 400;
    localparam int  WATCHDOG_LIMIT = 4000;
    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
    localparam t_out_item NO_FLAGS = '0;

    // One row of the directed stimulus; the result is typed in only where has_want is set.
    typedef struct packed {
        logic [KIND_W-1:0]      kind;
        logic [SAMPLE_BITS-1:0] sample;
        logic [DIR_W-1:0]       move_dir;
        logic                   has_want;
        t_out_item              want;
    } t_directed_row;

    // Fresh from reset nothing is armed and every flag is clear, so each evaluate reads 0000.
    localparam t_directed_row DIRECTED_ROWS [16] = '{
        '{KIND_EVALUATE, 12'h000, 3'd0, 1'b1, NO_FLAGS},
        '{KIND_SAMPLE,   12'h000, 3'd0, 1'b0, NO_FLAGS},
        '{KIND_SAMPLE,   12'hFFF, 3'd7, 1'b0, NO_FLAGS},
        '{KIND_SAMPLE,   12'hAAA, 3'd2, 1'b0, NO_FLAGS},
        '{KIND_SAMPLE,   12'h555, 3'd5, 1'b0, NO_FLAGS},
        '{KIND_EVALUATE, 12'hFFF, 3'd7, 1'b1, NO_FLAGS},
        '{KIND_CLEAR,    12'hFFF, 3'd7, 1'b0, NO_FLAGS},
        '{KIND_EVALUATE, 12'h000, 3'd1, 1'b1, NO_FLAGS},
        '{KIND_UNUSED,   12'hFFF, 3'd7, 1'b0, NO_FLAGS},
        '{KIND_EVALUATE, 12'h000, 3'd2, 1'b1, NO_FLAGS},
        '{KIND_EVALUATE, 12'h000, 3'd3, 1'b1, NO_FLAGS},
        '{KIND_EVALUATE, 12'h000, 3'd4, 1'b1, NO_FLAGS},
        '{KIND_EVALUATE, 12'h000, 3'd5, 1'b1, NO_FLAGS},
        '{KIND_EVALUATE, 12'h000, 3'd6, 1'b1, NO_FLAGS},
        '{KIND_SAMPLE,   12'h001, 3'd0, 1'b0, NO_FLAGS},
        '{KIND_EVALUATE, 12'h800, 3'd0, 1'b1, NO_FLAGS}
    };

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_in_valid = 1'b0;
    logic                   o_in_stall;
    t_in_item               i_in = '0;
    logic                   o_out_valid;
    logic                   i_out_stall = 1'b0;
    t_out_item              o_out;
    logic                   i_cfg_valid = 1'b0;
    logic                   o_cfg_ready;
    logic [CFG_IDX_W-1:0]   i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data = '0;

    // Shadow copy of the block's registers and state.
    logic [SKIP_W-1:0]      skip_reg;
    logic [LEVEL_W-1:0]     floor_reg;
    logic [LEVEL_W-1:0]     cap_reg;
    logic [LEVEL_W-1:0]     knee_reg;
    logic [MARGIN_W-1:0]    margin_reg;
    logic [SAMPLE_BITS-1:0] ring_slot [CHANNELS][RING_DEPTH];
    logic [15:0]            chan_total [CHANNELS];
    logic [3:0]             slot_ptr [CHANNELS];
    logic [3:0]             slot_count [CHANNELS];
    logic [LEVEL_W-1:0]     chan_thr [CHANNELS];
    logic [SAMPLE_BITS-1:0] left_ref;
    logic [SAMPLE_BITS-1:0] right_ref;
    logic [CH_W-1:0]        next_chan;
    logic [SKIP_W-1:0]      skip_seen;
    t_press_flags           held_flags;

    t_out_item pending_flags [$];
    int        mismatch_count = 0;
    int        requests_sent = 0;
    int        quiet_cycles = 0;
    int        idle_pct = 33;
    bit        hold_pending = 1'b0;

    bumper_threshold_detector dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Average of one channel's ring.
    function automatic logic [SAMPLE_BITS-1:0] chan_level(input int c);
        return SAMPLE_BITS'(chan_total[c] / RING_DEPTH);
    endfunction

    function automatic logic [LEVEL_W-1:0] raise_to_floor(input logic [31:0] t);
        return (t < 32'(floor_reg)) ? floor_reg : LEVEL_W'(t);
    endfunction

    // Corner threshold: the cap above the knee, otherwise four fifths of the average, at most the cap.
    function automatic logic [LEVEL_W-1:0] corner_level(input logic [SAMPLE_BITS-1:0] lvl);
        logic [31:0] scaled;
        scaled = 32'(lvl) * 32'd4 / 32'd5;
        if (lvl > knee_reg) return cap_reg;
        return (scaled > 32'(cap_reg)) ? cap_reg : LEVEL_W'(scaled);
    endfunction

    // Advances the shadow state by one request; returns 1 with the flags when a result follows.
    function automatic bit bumper_response(input t_in_item req, output t_out_item flags);
        int c;
        bit all_full;
        logic [SAMPLE_BITS-1:0] lvl;
        flags = NO_FLAGS;
        case (req.kind)
            KIND_SAMPLE: begin
                if (skip_seen >= skip_reg) begin
                    skip_seen = '0;
                    c = int'(next_chan);
                    chan_total[c] = chan_total[c] - 16'(ring_slot[c][slot_ptr[c]])
                                    + 16'(req.sample);
                    ring_slot[c][slot_ptr[c]] = req.sample;
                    slot_ptr[c] = slot_ptr[c] + 4'd1;
                    if (slot_count[c] < 4'(RING_DEPTH - 1)) slot_count[c] = slot_count[c] + 4'd1;
                    next_chan = (c == CHANNELS - 1) ? CH_LEFT_SIDE : CH_W'(c + 1);
                end else begin
                    skip_seen = skip_seen + 8'd1;
                end
                return 1'b0;
            end
            KIND_CLEAR: begin
                for (c = 0; c < CHANNELS; c++) chan_thr[c] = '0;
                return 1'b0;
            end
            KIND_EVALUATE: begin
                all_full = 1'b1;
                for (c = 0; c < CHANNELS; c++) begin
                    if (slot_count[c] != 4'(RING_DEPTH - 1)) all_full = 1'b0;
                end
                // Arm once every ring holds RING_DEPTH-1 samples and no threshold is in place.
                if (chan_thr[CH_LEFT_SIDE] == '0 && all_full) begin
                    chan_thr[CH_LEFT_SIDE]  = raise_to_floor(chan_level(CH_LEFT_SIDE) * 85 / 100);
                    chan_thr[CH_RIGHT_SIDE] = raise_to_floor(chan_level(CH_RIGHT_SIDE) * 85 / 100);
                    chan_thr[CH_BACK]       = raise_to_floor(chan_level(CH_BACK) * 85 / 100);
                    chan_thr[CH_FRONT_LEFT]  = raise_to_floor(32'(chan_level(CH_FRONT_LEFT)) / 2);
                    chan_thr[CH_FRONT_RIGHT] = raise_to_floor(32'(chan_level(CH_FRONT_RIGHT)) / 2);
                    left_ref  = chan_level(CH_LEFT_CORNER);
                    right_ref = chan_level(CH_RIGHT_CORNER);
                    chan_thr[CH_LEFT_CORNER]  = corner_level(left_ref);
                    chan_thr[CH_RIGHT_CORNER] = corner_level(right_ref);
                end
                // Armed: flags are rebuilt and the corners refreshed on direction or rise.
                if (chan_thr[CH_LEFT_SIDE] != '0) begin
                    held_flags = '0;
                    if (chan_level(CH_LEFT_SIDE) < chan_thr[CH_LEFT_SIDE]) held_flags.left = 1'b1;
                    if (chan_level(CH_RIGHT_SIDE) < chan_thr[CH_RIGHT_SIDE]) held_flags.right = 1'b1;
                    lvl = chan_level(CH_LEFT_CORNER);
                    if ((req.move_dir & DIR_LEFT_CORNER_MASK) != '0
                            || 32'(left_ref) + 32'(margin_reg) < 32'(lvl)) begin
                        chan_thr[CH_LEFT_CORNER] = corner_level(lvl);
                        left_ref = lvl;
                    end
                    lvl = chan_level(CH_RIGHT_CORNER);
                    if ((req.move_dir & DIR_RIGHT_CORNER_MASK) != '0
                            || 32'(right_ref) + 32'(margin_reg) < 32'(lvl)) begin
                        chan_thr[CH_RIGHT_CORNER] = corner_level(lvl);
                        right_ref = lvl;
                    end
                    if (chan_level(CH_BACK) < chan_thr[CH_BACK]) held_flags = '1;
                end
                flags.left_pressed    = held_flags.left;
                flags.right_pressed   = held_flags.right;
                flags.reverse_pressed = held_flags.reverse;
                flags.armed           = (chan_thr[CH_LEFT_SIDE] != '0);
                return 1'b1;
            end
            default: return 1'b0;
        endcase
    endfunction

    // Offers one request, holds it until taken, and records the flags it should give.
    task automatic send_item(input t_in_item req, input logic has_want, input t_out_item want);
        t_out_item flags;
        if ($urandom_range(0, 99) < idle_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(0, 99) < idle_pct);
        end
        i_in_valid <= 1'b1;
        i_in       <= req;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        if (bumper_response(req, flags)) pending_flags.push_back(has_want ? want : flags);
        if (req.kind != KIND_UNUSED) requests_sent++;
    endtask

    // Stops offering requests and lets every result and any sample still in flight finish.
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (pending_flags.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_reg idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            CFG_SKIP_COUNT:    skip_reg   = data[SKIP_W-1:0];
            CFG_FLOOR_LEVEL:   floor_reg  = data[LEVEL_W-1:0];
            CFG_CORNER_CAP:    cap_reg    = data[LEVEL_W-1:0];
            CFG_CORNER_KNEE:   knee_reg   = data[LEVEL_W-1:0];
            CFG_RECALC_MARGIN: margin_reg = data[MARGIN_W-1:0];
            default: ;
        endcase
    endtask

    // Writes the full register set once the block has gone quiet.
    task automatic set_registers(input int skip, input int floor_lvl, input int cap,
                                 input int knee, input int margin);
        wait_drained();
        write_reg(CFG_SKIP_COUNT, CFG_DATA_W'(skip));
        write_reg(CFG_FLOOR_LEVEL, CFG_DATA_W'(floor_lvl));
        write_reg(CFG_CORNER_CAP, CFG_DATA_W'(cap));
        write_reg(CFG_CORNER_KNEE, CFG_DATA_W'(knee));
        write_reg(CFG_RECALC_MARGIN, CFG_DATA_W'(margin));
        i_cfg_valid <= 1'b0;
    endtask

    // Bumper level for one channel: tiny, near or at full scale, or anywhere.
    function automatic int pick_level();
        case ($urandom_range(0, 5))
            0:       return int'($urandom_range(0, 1));
            1:       return int'($urandom_range(3800, SAMPLE_MAX));
            2:       return SAMPLE_MAX;
            default: return int'($urandom_range(0, SAMPLE_MAX));
        endcase
    endfunction

    // A conversion around the given level; the tiny and full-scale levels stay exact.
    function automatic logic [SAMPLE_BITS-1:0] noisy(input int level);
        int v;
        v = level;
        if (level > 1 && level < SAMPLE_MAX) v = level + int'($urandom_range(0, 16)) - 8;
        if (v < 0) v = 0;
        if (v > SAMPLE_MAX) v = SAMPLE_MAX;
        return SAMPLE_BITS'(v);
    endfunction

    // A run of conversions that follow per-channel levels, with evaluates mixed in.
    // Halfway through some levels drop, so armed evaluates see bumpers being pressed.
    task automatic run_episode(input bit low_left);
        int level [CHANNELS];
        int n_items;
        int k;
        int roll;
        t_in_item req;
        for (k = 0; k < CHANNELS; k++) level[k] = pick_level();
        if (low_left) level[CH_LEFT_SIDE] = 0;
        req = '0;
        if ($urandom_range(0, 2) == 0) begin
            req.kind = KIND_CLEAR;
            send_item(req, 1'b0, NO_FLAGS);
        end
        n_items = int'($urandom_range(40, 160));
        for (k = 0; k < n_items; k++) begin
            if (k == n_items / 2) begin
                foreach (level[c]) begin
                    if ($urandom_range(0, 1) == 1)
                        level[c] = level[c] * int'($urandom_range(0, 100)) / 100;
                end
            end
            roll = int'($urandom_range(0, 99));
            req.kind     = KIND_SAMPLE;
            req.sample   = noisy(level[next_chan]);
            req.move_dir = DIR_W'($urandom);
            if (roll < 1) begin
                req.kind   = KIND_UNUSED;
                req.sample = SAMPLE_BITS'($urandom);
            end else if (roll < 3) begin
                req.kind = KIND_CLEAR;
            end else if (roll < 15) begin
                req.kind = KIND_EVALUATE;
            end else if (roll < 22) begin
                req.sample = SAMPLE_BITS'($urandom);
            end
            send_item(req, 1'b0, NO_FLAGS);
        end
        req.kind     = KIND_EVALUATE;
        req.move_dir = DIR_W'($urandom);
        send_item(req, 1'b0, NO_FLAGS);
    endtask

    task automatic run_random(input int count, input bit low_left_first);
        int phase_end;
        phase_end = requests_sent + count;
        run_episode(low_left_first);
        while (requests_sent < phase_end) run_episode(1'b0);
    endtask

    // Result side: random stalls, plus one long hold-off on request.
    initial begin : out_pacing
        forever begin
            @(posedge i_clk);
            if (hold_pending) begin
                hold_pending = 1'b0;
                i_out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            i_out_stall <= ($urandom_range(0, 99) < idle_pct);
        end
    end

    function automatic void check_field(input string name, input logic want, input logic got);
        if (got !== want) begin
            $error("%s: expected %0b, got %0b", name, want, got);
            mismatch_count++;
        end
    endfunction

    // Each result taken is compared with the oldest expectation.
    always @(posedge i_clk) begin : result_check
        t_out_item want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_flags.size() == 0) begin
                $error("result with no request waiting: %b", o_out);
                mismatch_count++;
            end else begin
                want = pending_flags.pop_front();
                check_field("left_pressed", want.left_pressed, o_out.left_pressed);
                check_field("right_pressed", want.right_pressed, o_out.right_pressed);
                check_field("reverse_pressed", want.reverse_pressed, o_out.reverse_pressed);
                check_field("armed", want.armed, o_out.armed);
            end
        end
    end

    // Ends the run if nothing moves on any channel for too long.
    always @(posedge i_clk) begin : watchdog
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
                || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    initial begin : stimulus
        int c;
        int k;
        skip_reg   = SKIP_COUNT_RST;
        floor_reg  = FLOOR_LEVEL_RST;
        cap_reg    = CORNER_CAP_RST;
        knee_reg   = CORNER_KNEE_RST;
        margin_reg = RECALC_MARGIN_RST;
        for (c = 0; c < CHANNELS; c++) begin
            for (k = 0; k < RING_DEPTH; k++) ring_slot[c][k] = '0;
            chan_total[c] = '0;
            slot_ptr[c]   = '0;
            slot_count[c] = '0;
            chan_thr[c]   = '0;
        end
        left_ref   = '0;
        right_ref  = '0;
        next_chan  = CH_LEFT_SIDE;
        skip_seen  = '0;
        held_flags = '0;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed requests under the reset settings.
        foreach (DIRECTED_ROWS[k]) begin
            send_item('{DIRECTED_ROWS[k].kind, DIRECTED_ROWS[k].sample, DIRECTED_ROWS[k].move_dir},
                      DIRECTED_ROWS[k].has_want, DIRECTED_ROWS[k].want);
        end

        // Every conversion kept and all limits low but the corner cap; the first fill arms to zero.
        set_registers(0, 0, SAMPLE_MAX, 0, 0);
        hold_pending = 1'b1;
        run_random(500, 1'b1);

        // Almost every conversion discarded and all limits high but the corner cap.
        set_registers(255, SAMPLE_MAX, 0, SAMPLE_MAX, 255);
        run_random(300, 1'b0);

        // Reset-like limits with no idling on either side.
        set_registers(2, 400, 300, 330, 5);
        idle_pct = 0;
        run_random(500, 1'b0);
        idle_pct = 33;

        set_registers(int'($urandom_range(0, 7)), int'($urandom_range(0, 2000)),
                      int'($urandom_range(0, SAMPLE_MAX)), int'($urandom_range(0, SAMPLE_MAX)),
                      int'($urandom_range(0, 255)));
        run_random(500, 1'b0);

        wait_drained();
        if (mismatch_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
